// ===== rtl/scbp_pkg.sv =====
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and constants for the serial command byte parser.
// ----------------------------------------------------------------------------
package scbp_pkg;

   // ASCII codes recognized by the parser
   localparam logic [7:0] ASCII_A    = 8'h41;
   localparam logic [7:0] ASCII_B    = 8'h42;
   localparam logic [7:0] ASCII_C    = 8'h43;
   localparam logic [7:0] ASCII_P    = 8'h50;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_ONE  = 8'h31;
   localparam logic [7:0] ASCII_TWO  = 8'h32;
   localparam logic [7:0] ASCII_THREE = 8'h33;

   // Decimal place weights for the duty digits
   localparam logic [7:0] WEIGHT_HUNDREDS = 8'd100;
   localparam logic [7:0] WEIGHT_TENS     = 8'd10;

   // Result command codes
   typedef enum logic [1:0] {
      CMD_READ_CH3 = 2'd0,
      CMD_READ_CH0 = 2'd1,
      CMD_MEASURE  = 2'd2,
      CMD_SET_DUTY = 2'd3
   } command_type;

   // One result item
   typedef struct packed {
      command_type command;
      logic [1:0]  duty_channel;
      logic [7:0]  duty_value;
   } rsp_type;

   // Decoder output toward the result register
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } result_type;

endpackage

// ===== rtl/scbp_decode.sv =====
// ----------------------------------------------------------------------------
// scbp_decode
// Command state machine: consumes one byte per fire, collects the duty
// command bytes and produces at most one result item per byte.
// ----------------------------------------------------------------------------
module scbp_decode
   import scbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] byte_in,
   output result_type result
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAN,
      ST_DIG_A,
      ST_DIG_B,
      ST_DIG_C
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] chan_ff, chan_in;
   logic [7:0] dig_a_ff, dig_a_in;
   logic [7:0] dig_b_ff, dig_b_in;

   logic       chan_ok;
   logic [7:0] duty_sum;

   // Channel must be '1'..'3'; duty is 100a + 10b + c, wrapped to 8 bits
   assign chan_ok  = (chan_ff == ASCII_ONE) || (chan_ff == ASCII_TWO) ||
                     (chan_ff == ASCII_THREE);
   assign duty_sum = WEIGHT_HUNDREDS * (dig_a_ff - ASCII_ZERO)
                   + WEIGHT_TENS * (dig_b_ff - ASCII_ZERO)
                   + (byte_in - ASCII_ZERO);

   // Next state and result
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      dig_a_in = dig_a_ff;
      dig_b_in = dig_b_ff;
      result   = '0;
      if (fire) begin
         case (state_ff)
            ST_IDLE: begin
               case (byte_in)
                  ASCII_A: begin
                     result.valid       = 1'b1;
                     result.rsp.command = CMD_READ_CH3;
                  end
                  ASCII_B: begin
                     result.valid       = 1'b1;
                     result.rsp.command = CMD_READ_CH0;
                  end
                  ASCII_C: begin
                     result.valid       = 1'b1;
                     result.rsp.command = CMD_MEASURE;
                  end
                  ASCII_P: begin
                     state_in = ST_CHAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
            ST_CHAN: begin
               chan_in  = byte_in;
               state_in = ST_DIG_A;
            end
            ST_DIG_A: begin
               dig_a_in = byte_in;
               state_in = ST_DIG_B;
            end
            ST_DIG_B: begin
               dig_b_in = byte_in;
               state_in = ST_DIG_C;
            end
            ST_DIG_C: begin
               state_in = ST_IDLE;
               // bad channel drops the command silently
               if (chan_ok) begin
                  result.valid            = 1'b1;
                  result.rsp.command      = CMD_SET_DUTY;
                  result.rsp.duty_channel = chan_ff[1:0];
                  result.rsp.duty_value   = duty_sum;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // State and collected bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      chan_ff  <= chan_in;
      dig_a_ff <= dig_a_in;
      dig_b_ff <= dig_b_in;
   end

endmodule

// ===== rtl/serial_command_byte_parser.sv =====
// ----------------------------------------------------------------------------
// serial_command_byte_parser
// Recognizes single-byte read/measure commands and five-byte duty commands
// from a stream of received serial bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one received byte per item on req_rx_byte.
//   Result channel rsp_*: command, duty channel and duty value. 'A', 'B' and
//   'C' in idle each give one item; 'P' + channel + three digits gives one
//   set-duty item on the last byte, or none if the channel is not '1'..'3'.
//   All other bytes give no item.
//   Path: an accepted byte waits in the input register, then is decoded
//   into the result register, which drives rsp_* until it is taken.
//   Throughput: one byte per cycle while rsp_stall is low; the decoder
//   state machine updates once per byte and the result register frees
//   itself as the receiver takes it.
//   Stall: while rsp_stall holds a waiting result, one more byte may sit in
//   the input register; req_stall then rises until the result is taken.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to idle; a partly received duty command is discarded.
// ----------------------------------------------------------------------------
module serial_command_byte_parser
   import scbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_command,
   output logic [1:0] rsp_duty_channel,
   output logic [7:0] rsp_duty_value
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   logic       req_accept;
   logic       in_move;
   result_type result;

   // Input register moves on when the result register is free or draining
   assign in_move    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !in_move;
   assign req_accept = req_valid && !req_stall;

   scbp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (in_move),
      .byte_in (in_byte_ff),
      .result  (result)
   );

   // Next values of both registers
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
      if (in_move) begin
         out_valid_in = result.valid;
         if (result.valid) begin
            out_data_in = result.rsp;
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command      = out_data_ff.command;
   assign rsp_duty_channel = out_data_ff.duty_channel;
   assign rsp_duty_value   = out_data_ff.duty_value;

endmodule

// ===== rtl/scbp_checker.sv =====
// ----------------------------------------------------------------------------
// scbp_checker
// Port-level checks for the serial command byte parser, bound to the top.
// ----------------------------------------------------------------------------
module scbp_checker
   import scbp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_command,
   input logic [1:0] rsp_duty_channel,
   input logic [7:0] rsp_duty_value
);

   // A stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command) &&
      $stable(rsp_duty_channel) && $stable(rsp_duty_value))
      else $error("result item changed while stalled");

   // Only set duty carries a channel and a duty value
   a_non_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command != CMD_SET_DUTY) |->
      (rsp_duty_channel == 2'd0) && (rsp_duty_value == 8'd0))
      else $error("non-duty item has duty fields set");

   // Set duty always names a real channel
   a_duty_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_SET_DUTY) |-> (rsp_duty_channel != 2'd0))
      else $error("set duty item with channel zero");

   // A fresh result must come from an accepted input item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result item without an accepted input item");

   // Read channel 3 can only come from an 'A' byte
   a_read_ch3_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && (rsp_command == CMD_READ_CH3) |->
      $past(req_rx_byte, 2) == ASCII_A)
      else $error("read channel 3 item not caused by 'A'");

endmodule

bind serial_command_byte_parser scbp_checker u_scbp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_command      (rsp_command),
   .rsp_duty_channel (rsp_duty_channel),
   .rsp_duty_value   (rsp_duty_value)
);

// ===== tb/sv/serial_command_byte_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_byte_parser_checker
// Watches both channels of the serial command byte parser. Every byte the
// parser takes is run through a local copy of the command decoder, and each
// command it yields is queued. Every result item the receiver takes is
// compared field by field with the oldest queued command.
// ----------------------------------------------------------------------------
module serial_command_byte_parser_checker
   import scbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_command,
   input  logic [1:0] rsp_duty_channel,
   input  logic [7:0] rsp_duty_value,
   output int         fail_count,
   output int         pending_count
);

   // local decoder state
   logic [2:0] parse_position;
   logic [7:0] duty_bytes [0:3];

   rsp_type decoded_commands [$];
   rsp_type oldest_command;
   rsp_type next_command;
   int      mismatch_total;

   assign fail_count = mismatch_total;

   initial begin
      mismatch_total = 0;
      pending_count  = 0;
      parse_position = 3'd0;
   end

   task automatic report_mismatch(input string note);
      $display("[%0t] mismatch: %s", $realtime, note);
      mismatch_total++;
   endtask

   // Feed one byte to the decoder; returns 1 with the command when one completes
   function automatic logic decode_rx_byte(input logic [7:0] value, output rsp_type command);
      logic [7:0] channel_byte;
      logic [7:0] channel_number;
      logic [7:0] duty;
      command = '0;
      // idle: single-byte commands, or the start of a duty command
      if (parse_position == 3'd0 || parse_position > 3'd4) begin
         parse_position = 3'd0;
         case (value)
            ASCII_A: begin
               command.command = CMD_READ_CH3;
               return 1'b1;
            end
            ASCII_B: begin
               command.command = CMD_READ_CH0;
               return 1'b1;
            end
            ASCII_C: begin
               command.command = CMD_MEASURE;
               return 1'b1;
            end
            ASCII_P: parse_position = 3'd1;
            default: ;
         endcase
         return 1'b0;
      end
      // collecting channel and digit bytes
      duty_bytes[parse_position - 3'd1] = value;
      if (parse_position < 3'd4) begin
         parse_position = parse_position + 3'd1;
         return 1'b0;
      end
      parse_position = 3'd0;
      channel_byte = duty_bytes[0];
      if (channel_byte != ASCII_ONE && channel_byte != ASCII_TWO &&
          channel_byte != ASCII_THREE)
         return 1'b0;
      // 8-bit arithmetic wraps the digit sum modulo 256
      duty = WEIGHT_HUNDREDS * (duty_bytes[1] - ASCII_ZERO)
           + WEIGHT_TENS * (duty_bytes[2] - ASCII_ZERO)
           + (duty_bytes[3] - ASCII_ZERO);
      channel_number = channel_byte - ASCII_ZERO;
      command.command      = CMD_SET_DUTY;
      command.duty_channel = channel_number[1:0];
      command.duty_value   = duty;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         parse_position = 3'd0;
         decoded_commands.delete();
      end else begin
         // result side: compare with the oldest decoded command
         if (rsp_valid && !rsp_stall) begin
            if (decoded_commands.size() == 0) begin
               report_mismatch($sformatf("unexpected item command %0d channel %0d duty %0d",
                                         rsp_command, rsp_duty_channel, rsp_duty_value));
            end else begin
               oldest_command = decoded_commands.pop_front();
               if (rsp_command != oldest_command.command)
                  report_mismatch($sformatf("command got %0d, expected %0d",
                                            rsp_command, oldest_command.command));
               if (rsp_duty_channel != oldest_command.duty_channel)
                  report_mismatch($sformatf("duty_channel got %0d, expected %0d",
                                            rsp_duty_channel, oldest_command.duty_channel));
               if (rsp_duty_value != oldest_command.duty_value)
                  report_mismatch($sformatf("duty_value got %0d, expected %0d",
                                            rsp_duty_value, oldest_command.duty_value));
            end
         end
         // input side: decode each accepted byte
         if (req_valid && !req_stall) begin
            if (decode_rx_byte(req_rx_byte, next_command))
               decoded_commands.push_back(next_command);
         end
      end
      pending_count <= decoded_commands.size();
   end

endmodule

// ===== tb/sv/serial_command_byte_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_byte_parser_tb
// Drives byte streams into the serial command byte parser: a directed run
// over the command set and its corner cases, then random commands mixed with
// broken sequences and noise, with random gaps and receiver stalls. The
// checker beside the parser predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module serial_command_byte_parser_tb;
   import scbp_pkg::*;

   localparam int RANDOM_BYTES = 1450;
   localparam int LONG_HOLD    = 250;
   localparam int CYCLE_LIMIT  = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_command;
   logic [1:0] rsp_duty_channel;
   logic [7:0] rsp_duty_value;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   logic req_quiet = 1'b0;
   logic rsp_quiet = 1'b0;

   always #5 clock = ~clock;

   serial_command_byte_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_duty_channel (rsp_duty_channel),
      .rsp_duty_value   (rsp_duty_value)
   );

   serial_command_byte_parser_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_duty_channel (rsp_duty_channel),
      .rsp_duty_value   (rsp_duty_value),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                  pending_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offer one byte after a random gap and hold it until it is taken
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = req_quiet ? 0 : int'($urandom_range(0, 16));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: random stalls per item, two long hold-offs to back up the parser
   initial begin : result_receiver
      int hold;
      int taken;
      taken = 0;
      @(posedge clock);
      forever begin
         if (taken == 30 || taken == 300)
            hold = LONG_HOLD;
         else
            hold = rsp_quiet ? 0 : int'($urandom_range(0, 16));
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken % 40 == 0)
            rsp_quiet = ($urandom_range(0, 2) == 0);
      end
   end

   // stimulus and verdict
   initial begin : byte_source
      logic [7:0] directed_bytes [0:24];
      logic [7:0] pick_byte;
      int counted;
      int pick;
      int extra;
      int rounds;

      // single commands, field extremes, then duty commands with corner cases
      directed_bytes = '{
         ASCII_A, ASCII_B, ASCII_C, 8'h00, 8'hFF,
         // 255 on channel 1
         ASCII_P, ASCII_ONE, ASCII_TWO, ASCII_ZERO + 8'd5, ASCII_ZERO + 8'd5,
         // 999 wraps to 231
         ASCII_P, ASCII_THREE, ASCII_ZERO + 8'd9, ASCII_ZERO + 8'd9, ASCII_ZERO + 8'd9,
         // channel '4' is rejected
         ASCII_P, ASCII_ZERO + 8'd4, ASCII_ONE, ASCII_TWO, ASCII_THREE,
         // non-digit duty bytes, 'P' taken as a digit
         ASCII_P, ASCII_TWO, 8'hFF, 8'h00, ASCII_P
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);

      // random part: mostly well-formed commands
      counted = 0;
      rounds  = 0;
      while (counted < RANDOM_BYTES) begin
         rounds++;
         if (rounds % 60 == 0)
            req_quiet = ($urandom_range(0, 3) == 0);
         pick = int'($urandom_range(0, 99));
         if (pick < 55) begin
            // duty command, sometimes with a bad channel or non-digit bytes
            send_byte(ASCII_P);
            if ($urandom_range(0, 9) == 0)
               pick_byte = 8'($urandom_range(0, 255));
            else
               pick_byte = ASCII_ONE + 8'($urandom_range(0, 2));
            send_byte(pick_byte);
            repeat (3) begin
               if ($urandom_range(0, 7) == 0)
                  pick_byte = 8'($urandom_range(0, 255));
               else
                  pick_byte = ASCII_ZERO + 8'($urandom_range(0, 9));
               send_byte(pick_byte);
            end
            counted += 5;
         end else if (pick < 85) begin
            pick_byte = ASCII_A + 8'($urandom_range(0, 2));
            send_byte(pick_byte);
            counted++;
         end else if (pick < 93) begin
            // cut-off duty command; the next bytes get folded into it
            send_byte(ASCII_P);
            extra = int'($urandom_range(1, 3));
            repeat (extra) begin
               pick_byte = 8'($urandom_range(0, 255));
               send_byte(pick_byte);
            end
            counted += 1 + extra;
         end else begin
            pick_byte = 8'($urandom_range(0, 255));
            send_byte(pick_byte);
            counted++;
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
